// ----- rtl/rltm_pkg.sv -----
// Shared types and constants for the redo log transaction manager.
// No dependencies; every other file of the block imports this package.
`default_nettype none

package rltm_pkg;

    localparam int LOG_CAPACITY = 30;

    localparam int BLK_W     = 32;
    localparam int OPCODE_W  = 2;
    localparam int KIND_W    = 4;
    localparam int CNT_W     = 5;
    localparam int OPS_W     = 6;
    localparam int CFG_IDX_W = 4;
    localparam int NEED_W    = 12;

    localparam logic [OPS_W-1:0] OPS_MAX = '1;

    // opcodes
    localparam logic [OPCODE_W-1:0] OP_BEGIN = 2'd0;
    localparam logic [OPCODE_W-1:0] OP_END   = 2'd1;
    localparam logic [OPCODE_W-1:0] OP_WRITE = 2'd2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_LOG_AREA_START  = 4'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LOG_AREA_BLOCKS = 4'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ADMIT_LIMIT     = 4'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_BLOCKS_PER_OP   = 4'd3;

    typedef enum logic [KIND_W-1:0] {
        KIND_ADMIT   = 4'd0,
        KIND_WAIT    = 4'd1,
        KIND_ENDED   = 4'd2,
        KIND_ABSORB  = 4'd3,
        KIND_ADDED   = 4'd4,
        KIND_COPY    = 4'd5,
        KIND_HEADER  = 4'd6,
        KIND_INSTALL = 4'd7,
        KIND_FULL    = 4'd8,
        KIND_NOOP    = 4'd9,
        KIND_EMPTY   = 4'd10
    } kind_t;

    // controller -> datapath
    typedef struct packed {
        logic                take_en;
        logic                emit;
        kind_t               kind;
        logic                last;
        logic                idx_clr;
        logic                idx_inc;
        logic                open_inc;
        logic                open_dec;
        logic                entry_add;
        logic                entry_clr;
    } rltm_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic                req_valid;
        logic [OPCODE_W-1:0] opcode;
        logic                out_free;
        logic                admit_ok;
        logic                full;
        logic                open_zero;
        logic                open_one;
        logic                entry_zero;
        logic                match;
        logic                idx_last;
    } rltm_sts_t;

endpackage

`default_nettype wire

// ----- rtl/rltm_ifs.sv -----
// Channel interfaces: request in, result out, configuration write.
// Depends on rltm_pkg for field widths.
`default_nettype none

interface rltm_req_if;
    import rltm_pkg::*;
    logic                valid;
    logic                ready;
    logic [OPCODE_W-1:0] opcode;
    logic [BLK_W-1:0]    block_number;

    modport source (output valid, opcode, block_number, input ready);
    modport sink   (input valid, opcode, block_number, output ready);
endinterface

interface rltm_rsp_if;
    import rltm_pkg::*;
    logic              valid;
    logic              ready;
    logic [KIND_W-1:0] kind;
    logic [BLK_W-1:0]  source_block;
    logic [BLK_W-1:0]  dest_block;
    logic [CNT_W-1:0]  header_count;
    logic [CNT_W-1:0]  slot_index;
    logic              wake_waiter;
    logic              last;

    modport source (output valid, kind, source_block, dest_block, header_count,
                    slot_index, wake_waiter, last, input ready);
    modport sink   (input valid, kind, source_block, dest_block, header_count,
                    slot_index, wake_waiter, last, output ready);
endinterface

interface rltm_cfg_if;
    import rltm_pkg::*;
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [BLK_W-1:0]     data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ----- rtl/redo_log_transaction_manager.sv -----
// Top level of the group-commit redo log transaction manager.
// Depends on rltm_pkg, rltm_ifs, rltm_ctrl and rltm_datapath.
//
//  channel | modport | payload                                   | handshake
//  --------+---------+-------------------------------------------+-----------
//  req     | sink    | opcode, block_number                      | valid/ready
//  rsp     | source  | kind, source/dest_block, header_count,    | valid/ready
//          |         | slot_index, wake_waiter, last             |
//  cfg     | sink    | index, data                               | valid/ready
//
// One request at a time. A block write scans the stored table entries in turn (up
// to 29) through the single table read port. A commit of n entries issues 2n+2
// results, one per cycle while rsp accepts them. Reset clears the counters and
// sets config to its defaults; the table needs no clearing. A stalled rsp holds
// each step; req is taken while a result waits.
`default_nettype none

module redo_log_transaction_manager (
    input  wire logic   clk,
    input  wire logic   rst_n,
    rltm_req_if.sink    req,
    rltm_rsp_if.source  rsp,
    rltm_cfg_if.sink    cfg
);
    import rltm_pkg::*;

    rltm_cmd_t cmd;
    rltm_sts_t sts;

    rltm_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .sts   (sts),
        .cmd   (cmd)
    );

    rltm_datapath u_datapath (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd),
        .sts   (sts),
        .req   (req),
        .rsp   (rsp),
        .cfg   (cfg)
    );

endmodule

`default_nettype wire

// ----- rtl/rltm_datapath.sv -----
// Datapath: config registers, counters, block table, scan index, result register.
// Depends on rltm_pkg and rltm_ifs; driven by rltm_ctrl commands.
`default_nettype none

module rltm_datapath (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire rltm_pkg::rltm_cmd_t cmd,
    output rltm_pkg::rltm_sts_t     sts,
    rltm_req_if.sink                req,
    rltm_rsp_if.source              rsp,
    rltm_cfg_if.sink                cfg
);
    import rltm_pkg::*;

    logic [BLK_W-1:0]    log_area_start_reg;
    logic [CNT_W-1:0]    log_area_blocks_reg;
    logic [CNT_W-1:0]    admit_limit_reg;
    logic [CNT_W-1:0]    blocks_per_op_reg;

    logic [OPS_W-1:0]    open_ops_reg;
    logic [CNT_W-1:0]    entry_count_reg;
    logic [CNT_W-1:0]    idx_reg;
    logic [OPCODE_W-1:0] opcode_reg;
    logic [BLK_W-1:0]    blk_reg;

    logic [BLK_W-1:0]    tbl [LOG_CAPACITY];

    logic                out_valid_reg;
    logic [KIND_W-1:0]   out_kind_reg;
    logic [BLK_W-1:0]    out_src_reg;
    logic [BLK_W-1:0]    out_dst_reg;
    logic [CNT_W-1:0]    out_hdr_reg;
    logic [CNT_W-1:0]    out_slot_reg;
    logic                out_wake_reg;
    logic                out_last_reg;

    logic [BLK_W-1:0]    tbl_rd;
    logic [BLK_W-1:0]    log_addr;
    logic [OPS_W:0]      ops_p1;
    logic [NEED_W-1:0]   need;
    logic [CNT_W-1:0]    tbl_limit;
    logic [CNT_W:0]      idx_p1;
    logic                take;

    logic [BLK_W-1:0]    src_next;
    logic [BLK_W-1:0]    dst_next;
    logic [CNT_W-1:0]    hdr_next;
    logic [CNT_W-1:0]    slot_next;
    logic                wake_next;

    assign take      = req.valid && cmd.take_en;
    assign req.ready = cmd.take_en;
    assign cfg.ready = 1'b1;

    assign tbl_rd   = tbl[idx_reg];
    assign log_addr = log_area_start_reg + BLK_W'(idx_reg) + BLK_W'(1);
    assign ops_p1   = {1'b0, open_ops_reg} + (OPS_W+1)'(1);
    assign need     = NEED_W'(ops_p1) * NEED_W'(blocks_per_op_reg)
                      + NEED_W'(entry_count_reg);
    assign idx_p1   = {1'b0, idx_reg} + (CNT_W+1)'(1);

    // usable table slots: area minus header, capped at the table depth
    always_comb
    begin
        if (log_area_blocks_reg == '0)
            tbl_limit = '0;
        else if (log_area_blocks_reg - CNT_W'(1) > CNT_W'(LOG_CAPACITY))
            tbl_limit = CNT_W'(LOG_CAPACITY);
        else
            tbl_limit = log_area_blocks_reg - CNT_W'(1);
    end

    always_comb
    begin
        sts            = '0;
        sts.req_valid  = req.valid;
        sts.opcode     = opcode_reg;
        sts.out_free   = !out_valid_reg || rsp.ready;
        sts.admit_ok   = (open_ops_reg != OPS_MAX) && (need <= NEED_W'(admit_limit_reg));
        sts.full       = entry_count_reg >= tbl_limit;
        sts.open_zero  = open_ops_reg == '0;
        sts.open_one   = open_ops_reg == OPS_W'(1);
        sts.entry_zero = entry_count_reg == '0;
        sts.match      = tbl_rd == blk_reg;
        sts.idx_last   = idx_p1 >= {1'b0, entry_count_reg};
    end

    always_comb
    begin
        src_next  = '0;
        dst_next  = '0;
        hdr_next  = '0;
        slot_next = '0;
        wake_next = 1'b0;
        case (cmd.kind)
            KIND_COPY:
            begin
                src_next = tbl_rd;
                dst_next = log_addr;
            end
            KIND_INSTALL:
            begin
                src_next = log_addr;
                dst_next = tbl_rd;
            end
            KIND_HEADER:
            begin
                // the clearing header write closes the commit
                hdr_next  = cmd.last ? '0 : entry_count_reg;
                wake_next = cmd.last;
            end
            KIND_ABSORB: slot_next = idx_reg;
            KIND_ADDED:  slot_next = entry_count_reg;
            KIND_ENDED:  wake_next = 1'b1;
            KIND_EMPTY:  wake_next = 1'b1;
            default:     ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            log_area_start_reg  <= '0;
            log_area_blocks_reg <= CNT_W'(31);
            admit_limit_reg     <= CNT_W'(30);
            blocks_per_op_reg   <= CNT_W'(10);
            open_ops_reg        <= '0;
            entry_count_reg     <= '0;
            idx_reg             <= '0;
            out_valid_reg       <= 1'b0;
        end
        else
        begin
            if (cfg.valid)
            begin
                case (cfg.index)
                    CFG_LOG_AREA_START:  log_area_start_reg  <= cfg.data;
                    CFG_LOG_AREA_BLOCKS: log_area_blocks_reg <= cfg.data[CNT_W-1:0];
                    CFG_ADMIT_LIMIT:     admit_limit_reg     <= cfg.data[CNT_W-1:0];
                    CFG_BLOCKS_PER_OP:   blocks_per_op_reg   <= cfg.data[CNT_W-1:0];
                    default:             ;
                endcase
            end

            if (cmd.open_inc)
                open_ops_reg <= open_ops_reg + OPS_W'(1);
            else if (cmd.open_dec)
                open_ops_reg <= open_ops_reg - OPS_W'(1);

            if (cmd.entry_clr)
                entry_count_reg <= '0;
            else if (cmd.entry_add)
                entry_count_reg <= entry_count_reg + CNT_W'(1);

            if (cmd.idx_clr)
                idx_reg <= '0;
            else if (cmd.idx_inc)
                idx_reg <= idx_p1[CNT_W-1:0];

            if (cmd.emit)
                out_valid_reg <= 1'b1;
            else if (rsp.ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            opcode_reg <= req.opcode;
            blk_reg    <= req.block_number;
        end
        if (cmd.entry_add)
            tbl[entry_count_reg] <= blk_reg;
        if (cmd.emit)
        begin
            out_kind_reg <= cmd.kind;
            out_src_reg  <= src_next;
            out_dst_reg  <= dst_next;
            out_hdr_reg  <= hdr_next;
            out_slot_reg <= slot_next;
            out_wake_reg <= wake_next;
            out_last_reg <= cmd.last;
        end
    end

    assign rsp.valid        = out_valid_reg;
    assign rsp.kind         = out_kind_reg;
    assign rsp.source_block = out_src_reg;
    assign rsp.dest_block   = out_dst_reg;
    assign rsp.header_count = out_hdr_reg;
    assign rsp.slot_index   = out_slot_reg;
    assign rsp.wake_waiter  = out_wake_reg;
    assign rsp.last         = out_last_reg;

endmodule

`default_nettype wire

// ----- rtl/rltm_ctrl.sv -----
// Controller state machine: decode, table scan and commit sequencing.
// Depends on rltm_pkg; talks to rltm_datapath through cmd/sts structs.
`default_nettype none

module rltm_ctrl (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire rltm_pkg::rltm_sts_t sts,
    output rltm_pkg::rltm_cmd_t     cmd
);
    import rltm_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECIDE,
        ST_SCAN,
        ST_COPY,
        ST_HDR,
        ST_INST,
        ST_CLR
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    // every emitting step waits until the result register can take a new result
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        cmd.kind   = KIND_ADMIT;
        case (state_reg)
            ST_IDLE:
            begin
                cmd.take_en = 1'b1;
                if (sts.req_valid)
                    state_next = ST_DECIDE;
            end
            ST_DECIDE:
            begin
                case (sts.opcode)
                    OP_BEGIN:
                    begin
                        if (sts.out_free)
                        begin
                            cmd.emit     = 1'b1;
                            cmd.last     = 1'b1;
                            cmd.kind     = sts.admit_ok ? KIND_ADMIT : KIND_WAIT;
                            cmd.open_inc = sts.admit_ok;
                            state_next   = ST_IDLE;
                        end
                    end
                    OP_END:
                    begin
                        if (sts.open_zero || !sts.open_one || sts.entry_zero)
                        begin
                            if (sts.out_free)
                            begin
                                cmd.emit     = 1'b1;
                                cmd.last     = 1'b1;
                                cmd.open_dec = !sts.open_zero;
                                if (sts.open_zero)
                                    cmd.kind = KIND_NOOP;
                                else if (!sts.open_one)
                                    cmd.kind = KIND_ENDED;
                                else
                                    cmd.kind = KIND_EMPTY;
                                state_next = ST_IDLE;
                            end
                        end
                        else
                        begin
                            // last end with entries: start the commit
                            cmd.open_dec = 1'b1;
                            cmd.idx_clr  = 1'b1;
                            state_next   = ST_COPY;
                        end
                    end
                    OP_WRITE:
                    begin
                        if (sts.full || sts.open_zero || sts.entry_zero)
                        begin
                            if (sts.out_free)
                            begin
                                cmd.emit = 1'b1;
                                cmd.last = 1'b1;
                                if (sts.full)
                                    cmd.kind = KIND_FULL;
                                else if (sts.open_zero)
                                    cmd.kind = KIND_NOOP;
                                else
                                begin
                                    cmd.kind      = KIND_ADDED;
                                    cmd.entry_add = 1'b1;
                                end
                                state_next = ST_IDLE;
                            end
                        end
                        else
                        begin
                            cmd.idx_clr = 1'b1;
                            state_next  = ST_SCAN;
                        end
                    end
                    default: state_next = ST_IDLE;
                endcase
            end
            ST_SCAN:
            begin
                if (sts.match || sts.idx_last)
                begin
                    if (sts.out_free)
                    begin
                        cmd.emit      = 1'b1;
                        cmd.last      = 1'b1;
                        cmd.kind      = sts.match ? KIND_ABSORB : KIND_ADDED;
                        cmd.entry_add = !sts.match;
                        state_next    = ST_IDLE;
                    end
                end
                else
                    cmd.idx_inc = 1'b1;
            end
            ST_COPY:
            begin
                if (sts.out_free)
                begin
                    cmd.emit = 1'b1;
                    cmd.kind = KIND_COPY;
                    if (sts.idx_last)
                    begin
                        cmd.idx_clr = 1'b1;
                        state_next  = ST_HDR;
                    end
                    else
                        cmd.idx_inc = 1'b1;
                end
            end
            ST_HDR:
            begin
                if (sts.out_free)
                begin
                    cmd.emit   = 1'b1;
                    cmd.kind   = KIND_HEADER;
                    state_next = ST_INST;
                end
            end
            ST_INST:
            begin
                if (sts.out_free)
                begin
                    cmd.emit = 1'b1;
                    cmd.kind = KIND_INSTALL;
                    if (sts.idx_last)
                        state_next = ST_CLR;
                    else
                        cmd.idx_inc = 1'b1;
                end
            end
            ST_CLR:
            begin
                if (sts.out_free)
                begin
                    cmd.emit      = 1'b1;
                    cmd.last      = 1'b1;
                    cmd.kind      = KIND_HEADER;
                    cmd.entry_clr = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

endmodule

`default_nettype wire
